// ===== hdl/dsu_pkg.sv =====
package dsu_pkg;

	localparam int unsigned NUM_BITS = 32;
	localparam int unsigned SUM_BITS = NUM_BITS + 3;
	localparam int unsigned CNT_W    = $clog2(NUM_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_CHECK,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture n, seed sum and trial divisor
		logic div_start; // arm the divider for the current d
		logic div_step;  // one restoring step
		logic accum;     // fold in d and n/d when d divides n, then d++
		logic out_load;  // move result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic trivial;   // n is 0 or 1: no trial division needed
		logic div_last;  // final divider step this cycle
		logic quo_lt_d;  // n/d < d, scan is over
		logic out_free;  // output register can take a new result
	} stat_t;

endpackage

// ===== hdl/dsu_if.sv =====
interface dsu_in_if;
	logic                         valid;
	logic                         ready;
	logic [dsu_pkg::NUM_BITS-1:0] number_in;

	modport source (output valid, output number_in, input ready);
	modport sink   (input valid, input number_in, output ready);
endinterface

interface dsu_out_if;
	logic                         valid;
	logic                         ready;
	logic [dsu_pkg::SUM_BITS-1:0] divisor_sum;
	logic                         bad_input;

	modport source (output valid, output divisor_sum, output bad_input, input ready);
	modport sink   (input valid, input divisor_sum, input bad_input, output ready);
endinterface

// ===== hdl/dsu_ctrl.sv =====
module dsu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dsu_pkg::stat_t  stat,
	output dsu_pkg::cmd_t   cmd
);

	dsu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			dsu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = dsu_pkg::ST_START;
				end
			end
			dsu_pkg::ST_START: begin
				if (stat.trivial) begin
					state_d = dsu_pkg::ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = dsu_pkg::ST_DIV;
				end
			end
			dsu_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = dsu_pkg::ST_CHECK;
				end
			end
			dsu_pkg::ST_CHECK: begin
				if (stat.quo_lt_d) begin
					state_d = dsu_pkg::ST_FINISH;
				end else begin
					cmd.accum = 1'b1;
					state_d   = dsu_pkg::ST_START;
				end
			end
			dsu_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = dsu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dsu_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/dsu_dpath.sv =====
module dsu_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [dsu_pkg::NUM_BITS-1:0] number_in,
	input  dsu_pkg::cmd_t                cmd,
	output dsu_pkg::stat_t               stat,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dsu_pkg::SUM_BITS-1:0] divisor_sum,
	output logic                         bad_input
);

	localparam int unsigned NB = dsu_pkg::NUM_BITS;
	localparam int unsigned SB = dsu_pkg::SUM_BITS;
	localparam int unsigned CW = dsu_pkg::CNT_W;

	logic [NB-1:0] n_q;
	logic [NB-1:0] d_q;
	logic [SB-1:0] sum_q;
	logic          bad_q;
	logic [NB-1:0] rem_q;
	logic [NB-1:0] quo_q;
	logic [CW-1:0] cnt_q;

	logic          out_valid_q;
	logic [SB-1:0] out_sum_q;
	logic          out_bad_q;

	logic [NB:0]   rem_sh;
	logic          sub_ok;
	logic [NB:0]   rem_diff;
	logic [SB-1:0] q_add;

	// restoring divider, one quotient bit per cycle
	assign rem_sh   = {rem_q, quo_q[NB-1]};
	assign sub_ok   = rem_sh >= {1'b0, d_q};
	assign rem_diff = rem_sh - {1'b0, d_q};

	// d is counted once when it equals n/d
	assign q_add = (quo_q == d_q) ? '0 : SB'(quo_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= number_in;
			d_q   <= NB'(2);
			bad_q <= (number_in == '0);
			if (number_in == '0) begin
				sum_q <= '0;
			end else if (number_in == NB'(1)) begin
				sum_q <= SB'(1);
			end else begin
				sum_q <= SB'(number_in) + SB'(1);
			end
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= n_q;
			cnt_q <= CW'(NB);
		end
		if (cmd.div_step) begin
			rem_q <= sub_ok ? rem_diff[NB-1:0] : rem_sh[NB-1:0];
			quo_q <= {quo_q[NB-2:0], sub_ok};
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.accum) begin
			if (rem_q == '0) begin
				sum_q <= sum_q + SB'(d_q) + q_add;
			end
			d_q <= d_q + NB'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_sum_q <= sum_q;
			out_bad_q <= bad_q;
		end
	end

	assign stat.trivial  = (n_q[NB-1:1] == '0);
	assign stat.div_last = (cnt_q == CW'(1));
	assign stat.quo_lt_d = (quo_q < d_q);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign divisor_sum = out_sum_q;
	assign bad_input   = out_bad_q;

endmodule

// ===== hdl/divisor_sum_unit.sv =====
// Sum of divisors by trial division. Each item n yields sigma(n) and a flag for
// n == 0 (sum 0). Trial divisors d = 2, 3, ... share one restoring divider that
// makes one quotient bit per cycle; each d is armed, stepped NUM_BITS times and
// then checked, and the scan stops at the first d whose quotient falls below d.
// Inputs 0 and 1 need no trial division. One item is worked at a time; the
// result sits in an output register, and a new item is taken as soon as the
// result is latched there.
module divisor_sum_unit (
	input  logic      clk,
	input  logic      arst_n,
	dsu_in_if.sink    item,
	dsu_out_if.source result
);

	dsu_pkg::cmd_t  cmd;
	dsu_pkg::stat_t stat;

	dsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsu_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_in   (item.number_in),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.divisor_sum (result.divisor_sum),
		.bad_input   (result.bad_input)
	);

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bad_input |-> result.divisor_sum == '0)
		else $error("flagged result with nonzero sum");

	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.bad_input |-> result.divisor_sum != '0)
		else $error("valid input gave zero sum");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("new beat taken while item in progress");

endmodule
